FILE: hw/rtl/rtsq_pkg.sv
// shared types and constants of the record table
package rtsq_pkg;
  localparam int TableDepth = 64;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = IdxW + 1;
  localparam int KeyBytes = 20;
  localparam logic [6:0] AgeMax = 7'd120;

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_SORT   = 3'd2,
    ACT_QUERY  = 3'd3,
    ACT_READ   = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BAD_POS  = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTHING  = 3'd4
  } status_t;

  // one stored entry
  typedef struct packed {
    logic [63:0] head;
    logic [63:0] middle;
    logic [31:0] tail;
    logic [6:0]  age;
    logic [7:0]  tag;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  // keep only key bytes below KeyBytes in a field of nb bytes starting at first
  function automatic logic [63:0] key_mask(input int first, input int nb);
    logic [63:0] m;
    int cnt;
    m = '0;
    cnt = KeyBytes - first;
    for (int b = 0; b < 8; b++) begin
      if (b < nb && b < cnt) m[(nb - 1 - b) * 8 +: 8] = 8'hff;
    end
    return m;
  endfunction

  // unsigned key compare, a greater than b
  function automatic logic key_greater(input entry_t a, input entry_t b);
    return {a.head, a.middle, a.tail} > {b.head, b.middle, b.tail};
  endfunction
endpackage

FILE: hw/rtl/rtsq_in_if.sv
// input channel of the record table
interface rtsq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [6:0]  position;
  logic [63:0] key_head;
  logic [63:0] key_middle;
  logic [31:0] key_tail;
  logic [6:0]  age_value;
  logic [7:0]  record_tag;
  logic [6:0]  age_low;
  logic [6:0]  age_high;
  modport source (output valid, action, position, key_head, key_middle, key_tail,
                  age_value, record_tag, age_low, age_high, input ready);
  modport sink (input valid, action, position, key_head, key_middle, key_tail,
                age_value, record_tag, age_low, age_high, output ready);
endinterface

FILE: hw/rtl/rtsq_out_if.sv
// result channel of the record table
interface rtsq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [5:0]  entry_index;
  logic [63:0] out_key_head;
  logic [63:0] out_key_middle;
  logic [31:0] out_key_tail;
  logic [6:0]  out_age;
  logic [7:0]  out_tag;
  logic        last;
  modport source (output valid, status, entry_index, out_key_head, out_key_middle,
                  out_key_tail, out_age, out_tag, last, input ready);
  modport sink (input valid, status, entry_index, out_key_head, out_key_middle,
                out_key_tail, out_age, out_tag, last, output ready);
endinterface

FILE: hw/rtl/rtsq_ram.sv
// generic single-port-write, single-read synchronous ram
module rtsq_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/record_table_sort_query.sv
// top level of the record table: command sequencer over one entry ram
//
//  channel | dir | handshake     | payload
//  in      | in  | valid / ready | action, position, key, age, tag, age bounds
//  out     | out | valid / ready | status, index, key, age, tag, last
//
// one command at a time; every ram access is a registered read followed by a compare
// or write step, so insert and delete step through each moved entry, a query through
// each entry, and a sort through each compared pair plus an extra write step per swap.
// rst empties the table (count only).
// a full result register stalls the sequencer until the result is taken, and no
// new transaction is accepted while a result waits.
module record_table_sort_query (
  input logic       clk,
  input logic       rst,
  rtsq_in_if.sink   in,
  rtsq_out_if.source out
);
  localparam int IdxW = rtsq_pkg::IdxW;
  localparam int CntW = rtsq_pkg::CntW;

  typedef enum logic [3:0] {
    S_IDLE, S_SHIFT_RD, S_SHIFT_WR, S_INS_WR, S_DEL_RD, S_DEL_EMIT,
    S_SORT_RDI, S_SORT_RDJ, S_SORT_CMP, S_SORT_WRJ, S_Q_RD, S_Q_CHK, S_EMIT, S_DONE
  } state_t;

  state_t state;
  logic [2:0] act;
  logic [IdxW-1:0] pos, i_idx, j_idx;
  logic [CntW-1:0] count;
  rtsq_pkg::entry_t new_ent, ent_i, ent_j, rd_ent;
  logic [6:0] lo, hi;
  logic found;

  // query match held back until the next match or the end of the table
  rtsq_pkg::entry_t held;
  logic [5:0] held_idx;

  // ram interface
  logic we;
  logic [IdxW-1:0] waddr, raddr;
  rtsq_pkg::entry_t wdata;
  logic [rtsq_pkg::EntryW-1:0] rdata;

  rtsq_ram #(.Width(rtsq_pkg::EntryW), .Depth(rtsq_pkg::TableDepth)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );
  assign rd_ent = rtsq_pkg::entry_t'(rdata);

  // result register
  logic o_valid;
  rtsq_pkg::status_t o_status;
  logic [5:0] o_idx;
  rtsq_pkg::entry_t o_ent;
  logic o_last;

  assign out.valid = o_valid;
  assign out.status = o_status;
  assign out.entry_index = o_idx;
  assign out.out_key_head = o_ent.head;
  assign out.out_key_middle = o_ent.middle;
  assign out.out_key_tail = o_ent.tail;
  assign out.out_age = o_ent.age;
  assign out.out_tag = o_ent.tag;
  assign out.last = o_last;

  assign in.ready = (state == S_IDLE) && !o_valid;
  logic o_free;
  assign o_free = !o_valid || out.ready;

  // query match and end of table
  logic q_hit, q_end;
  assign q_hit = (rd_ent.age >= lo) && (rd_ent.age < hi);
  assign q_end = (CntW'(i_idx) + CntW'(1) == count);

  // a result is loaded into the result register this cycle
  logic emit;
  always_comb begin
    emit = 1'b0;
    unique case (state)
      S_DONE, S_EMIT: emit = o_free;
      S_DEL_EMIT:     emit = o_free && !found;
      S_Q_CHK:        emit = o_free && (act == rtsq_pkg::ACT_QUERY) && q_hit && found;
      default: ;
    endcase
  end

  // input key and age after masking and saturation
  rtsq_pkg::entry_t in_ent;
  always_comb begin
    in_ent.head = in.key_head & rtsq_pkg::key_mask(0, 8);
    in_ent.middle = in.key_middle & rtsq_pkg::key_mask(8, 8);
    in_ent.tail = in.key_tail & 32'(rtsq_pkg::key_mask(16, 4));
    in_ent.age = (in.age_value > rtsq_pkg::AgeMax) ? rtsq_pkg::AgeMax : in.age_value;
    in_ent.tag = in.record_tag;
  end

  // ram control follows state
  always_comb begin
    we = 1'b0;
    waddr = i_idx;
    wdata = new_ent;
    raddr = i_idx;
    unique case (state)
      S_SHIFT_RD: raddr = i_idx - IdxW'(1);
      S_SHIFT_WR: begin we = 1'b1; waddr = i_idx; wdata = rd_ent; end
      S_INS_WR:   begin we = 1'b1; waddr = pos; wdata = new_ent; end
      S_DEL_RD:   raddr = i_idx + IdxW'(1);
      S_DEL_EMIT: begin we = o_free && (CntW'(i_idx) + CntW'(1) < count);
                        waddr = i_idx; wdata = rd_ent; raddr = i_idx + IdxW'(1); end
      S_SORT_RDI: raddr = i_idx;
      S_SORT_RDJ: raddr = j_idx;
      S_SORT_CMP: begin
        we = rtsq_pkg::key_greater(ent_i, rd_ent);
        waddr = i_idx; wdata = rd_ent;
      end
      S_SORT_WRJ: begin we = 1'b1; waddr = j_idx; wdata = ent_j; end
      S_Q_RD:     raddr = i_idx;
      default: ;
    endcase
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (emit) begin
      o_valid <= 1'b1;
    end else if (out.ready) begin
      o_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in.valid && !o_valid) begin
          act <= in.action;
          pos <= in.position[IdxW-1:0];
          new_ent <= in_ent;
          lo <= in.age_low;
          hi <= in.age_high;
          found <= 1'b0;
          o_ent <= '0;
          o_idx <= '0;
          o_last <= 1'b1;
          priority case (in.action)
            rtsq_pkg::ACT_INSERT: begin
              if (count >= CntW'(rtsq_pkg::TableDepth)) begin
                o_status <= rtsq_pkg::ST_FULL; state <= S_DONE;
              end else if (in.position > 7'(count)) begin
                o_status <= rtsq_pkg::ST_BAD_POS; state <= S_DONE;
              end else begin
                i_idx <= count[IdxW-1:0];
                state <= (count[IdxW-1:0] == in.position[IdxW-1:0]) ? S_INS_WR : S_SHIFT_RD;
              end
            end
            rtsq_pkg::ACT_DELETE, rtsq_pkg::ACT_READ: begin
              if (count == '0) begin
                o_status <= rtsq_pkg::ST_EMPTY; state <= S_DONE;
              end else if (in.position >= 7'(count)) begin
                o_status <= rtsq_pkg::ST_BAD_POS; state <= S_DONE;
              end else begin
                i_idx <= in.position[IdxW-1:0];
                state <= S_Q_RD;
              end
            end
            rtsq_pkg::ACT_SORT: begin
              o_status <= rtsq_pkg::ST_OK;
              i_idx <= '0;
              j_idx <= IdxW'(1);
              state <= (count > CntW'(1)) ? S_SORT_RDI : S_DONE;
            end
            rtsq_pkg::ACT_QUERY: begin
              i_idx <= '0;
              if (count == '0) begin
                o_status <= rtsq_pkg::ST_NOTHING; state <= S_DONE;
              end else state <= S_Q_RD;
            end
            default: ;
          endcase
        end
        // insert: move entry i-1 up to i
        S_SHIFT_RD: state <= S_SHIFT_WR;
        S_SHIFT_WR: begin
          i_idx <= i_idx - IdxW'(1);
          state <= (i_idx - IdxW'(1) == pos) ? S_INS_WR : S_SHIFT_RD;
        end
        S_INS_WR: begin
          count <= count + CntW'(1);
          o_status <= rtsq_pkg::ST_OK;
          o_idx <= 6'(pos);
          o_ent <= new_ent;
          state <= S_DONE;
        end
        // read one entry then decide by action
        S_Q_CHK: begin
          if (act == rtsq_pkg::ACT_QUERY) begin
            // a second match must first push out the held one
            if (!(q_hit && found && !o_free)) begin
              if (q_hit) begin
                if (found) begin
                  o_status <= rtsq_pkg::ST_OK;
                  o_idx <= held_idx;
                  o_ent <= held;
                  o_last <= 1'b0;
                end
                held <= rd_ent;
                held_idx <= 6'(i_idx);
                found <= 1'b1;
              end
              if (q_end) state <= S_EMIT;
              else begin i_idx <= i_idx + IdxW'(1); state <= S_Q_RD; end
            end
          end else begin
            o_status <= rtsq_pkg::ST_OK;
            o_idx <= 6'(i_idx);
            o_ent <= rd_ent;
            o_last <= 1'b1;
            state <= (act == rtsq_pkg::ACT_DELETE) ? S_DEL_RD : S_DONE;
          end
        end
        S_Q_RD: state <= S_Q_CHK;
        // delete: emit removed entry, then pull later entries down
        S_DEL_RD: state <= S_DEL_EMIT;
        S_DEL_EMIT: if (o_free) begin
          found <= 1'b1;
          if (CntW'(i_idx) + CntW'(1) >= count) begin
            count <= count - CntW'(1); state <= S_IDLE;
          end else begin
            i_idx <= i_idx + IdxW'(1); state <= S_DEL_RD;
          end
        end
        // sort: entry i held in ent_i, compare with entry j
        S_SORT_RDI: state <= S_SORT_RDJ;
        S_SORT_RDJ: begin ent_i <= rd_ent; state <= S_SORT_CMP; end
        S_SORT_CMP: begin
          if (rtsq_pkg::key_greater(ent_i, rd_ent)) begin
            ent_j <= ent_i; ent_i <= rd_ent; state <= S_SORT_WRJ;
          end else if (CntW'(j_idx) + CntW'(1) < count) begin
            j_idx <= j_idx + IdxW'(1); state <= S_SORT_RDJ;
          end else if (CntW'(i_idx) + CntW'(2) < count) begin
            i_idx <= i_idx + IdxW'(1); j_idx <= i_idx + IdxW'(2); state <= S_SORT_RDI;
          end else state <= S_DONE;
        end
        S_SORT_WRJ: begin
          if (CntW'(j_idx) + CntW'(1) < count) begin
            j_idx <= j_idx + IdxW'(1); state <= S_SORT_RDJ;
          end else if (CntW'(i_idx) + CntW'(2) < count) begin
            i_idx <= i_idx + IdxW'(1); j_idx <= i_idx + IdxW'(2); state <= S_SORT_RDI;
          end else state <= S_DONE;
        end
        // end of query: last held match, or nothing found
        S_EMIT: if (o_free) begin
          o_status <= found ? rtsq_pkg::ST_OK : rtsq_pkg::ST_NOTHING;
          o_idx <= found ? held_idx : 6'd0;
          o_ent <= found ? held : '0;
          o_last <= 1'b1;
          state <= S_IDLE;
        end
        S_DONE: if (o_free) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
